[sv/ts_packet_header_parser_defines.svh]
// ----------------------------------------------------------------------------
// ts_packet_header_parser_defines.svh
// Assertion macros used by the checker file of the packet header parser.
// ----------------------------------------------------------------------------
`ifndef TS_PACKET_HEADER_PARSER_DEFINES_SVH
`define TS_PACKET_HEADER_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPH_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSPH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/tsph_pkg.sv]
// ----------------------------------------------------------------------------
// tsph_pkg
// Constants, error codes and transfer types of the packet header parser.
// ----------------------------------------------------------------------------
package tsph_pkg;

    localparam logic [7:0] PACKET_SIZE = 8'd188;
    localparam logic [7:0] SYNC_BYTE   = 8'h47;
    localparam logic [7:0] STUFF_BYTE  = 8'hFF;

    localparam int unsigned PID_BITS      = 13;
    localparam int unsigned PCR_BASE_BITS = 33;
    localparam int unsigned PCR_EXT_BITS  = 9;
    localparam int unsigned PCR_BITS      = 42;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_SYNC    = 2'd1;
    localparam logic [1:0] ERR_STUFF   = 2'd2;
    localparam logic [1:0] ERR_OVERRUN = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_of_packet;
    } in_item_t;

    typedef struct packed {
        logic [1:0]          error_code;
        logic [PID_BITS-1:0] pid;
        logic                payload_start;
        logic                transport_error;
        logic                priority_bit;
        logic [1:0]          scrambling;
        logic [1:0]          adaptation_control;
        logic [3:0]          continuity;
        logic [7:0]          af_flags;
        logic                pcr_valid;
        logic [PCR_BITS-1:0] pcr_value;
        logic [7:0]          payload_offset;
    } result_t;

endpackage

[sv/tsph_in_stage.sv]
// ----------------------------------------------------------------------------
// tsph_in_stage
// Input register: captures one byte transfer and holds it while the parser
// is blocked by a full, stalled result register.
// ----------------------------------------------------------------------------
module tsph_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         data_byte,
    input  logic               first_of_packet,
    input  logic               hold,
    output logic               item_valid,
    output tsph_pkg::in_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    tsph_pkg::in_item_t item_reg;
    logic               accept;

    assign in_stall   = valid_reg && hold;
    assign accept     = in_valid && !in_stall;
    assign valid_next = accept || (valid_reg && hold);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte       <= data_byte;
            item_reg.first_of_packet <= first_of_packet;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[sv/tsph_parse.sv]
// ----------------------------------------------------------------------------
// tsph_parse
// Packet parse state and its single-pass next-state logic: header decode,
// adaptation field walk, PCR capture, stuffing check and summary build.
// ----------------------------------------------------------------------------
module tsph_parse
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  tsph_pkg::in_item_t item,
    input  logic               advance,
    output logic               would_emit,
    output tsph_pkg::result_t  result
);

    localparam logic [3:0] PH_WAIT     = 4'd0;
    localparam logic [3:0] PH_HDR      = 4'd1;
    localparam logic [3:0] PH_AFLEN    = 4'd2;
    localparam logic [3:0] PH_AFFLAGS  = 4'd3;
    localparam logic [3:0] PH_PCR      = 4'd4;
    localparam logic [3:0] PH_OPCR     = 4'd5;
    localparam logic [3:0] PH_SPLICE   = 4'd6;
    localparam logic [3:0] PH_PRIVLEN  = 4'd7;
    localparam logic [3:0] PH_SKIPPRIV = 4'd8;
    localparam logic [3:0] PH_EXTLEN   = 4'd9;
    localparam logic [3:0] PH_EXTFLAGS = 4'd10;
    localparam logic [3:0] PH_SKIPEXT  = 4'd11;
    localparam logic [3:0] PH_STUFF    = 4'd12;
    localparam logic [3:0] PH_PAYLOAD  = 4'd13;
    localparam logic [3:0] PH_DRAIN    = 4'd14;

    localparam int unsigned ACC_BITS = 48;

    logic [7:0]          pos_reg,   pos_next;
    logic [3:0]          phase_reg, phase_next;
    logic [7:0]          aend_reg,  aend_next;
    logic [7:0]          skip_reg,  skip_next;
    logic [7:0]          eend_reg,  eend_next;
    logic [ACC_BITS-1:0] acc_reg,   acc_next;
    logic [23:0]         hf_reg,    hf_next;
    logic [7:0]          flags_reg, flags_next;
    logic                seen_reg,  seen_next;
    logic [1:0]          err_reg,   err_next;
    logic [7:0]          poff_reg,  poff_next;

    logic [7:0]          d;
    logic [7:0]          pos_inc;
    logic [8:0]          len_sum;
    logic [7:0]          len_end;
    logic [7:0]          skip_dec;
    logic [3:0]          ext_fields;
    logic [7:0]          ext_rem;
    logic [7:0]          ext_skip;
    logic                active;
    logic                do_next;
    logic [3:0]          nf_stage;
    logic                do_stuff;
    logic                do_finish;
    logic [1:0]          final_err;
    logic [PCR_BASE_BITS_W-1:0] pcr_base;
    logic [tsph_pkg::PCR_EXT_BITS-1:0] pcr_ext;
    logic [tsph_pkg::PCR_BITS-1:0]     base_wide;
    logic [tsph_pkg::PCR_BITS-1:0]     pcr_full;

    localparam int unsigned PCR_BASE_BITS_W = tsph_pkg::PCR_BASE_BITS;

    assign d        = item.data_byte;
    assign pos_inc  = pos_reg + 8'd1;
    assign len_sum  = {1'b0, pos_inc} + {1'b0, d};
    assign len_end  = len_sum[8] ? 8'hFF : len_sum[7:0];
    assign skip_dec = skip_reg - 8'd1;

    // Extension flag byte: LTW 2 bytes, piecewise rate 3, seamless splice 5
    assign ext_fields = (d[7] ? 4'd2 : 4'd0) + (d[6] ? 4'd3 : 4'd0) + (d[5] ? 4'd5 : 4'd0);
    assign ext_rem    = (eend_reg > pos_inc) ? (eend_reg - pos_inc) : 8'd0;
    assign ext_skip   = ({4'd0, ext_fields} > ext_rem) ? {4'd0, ext_fields} : ext_rem;

    always_comb
    begin
        pos_next   = pos_reg;
        phase_next = phase_reg;
        aend_next  = aend_reg;
        skip_next  = skip_reg;
        eend_next  = eend_reg;
        acc_next   = acc_reg;
        hf_next    = hf_reg;
        flags_next = flags_reg;
        seen_next  = seen_reg;
        err_next   = err_reg;
        poff_next  = poff_reg;
        active     = 1'b0;
        do_next    = 1'b0;
        nf_stage   = PH_PCR;
        do_stuff   = 1'b0;
        do_finish  = 1'b0;

        if (item_valid)
        begin
            if (item.first_of_packet)
            begin
                // restart: drop any open packet
                active     = 1'b1;
                pos_next   = 8'd1;
                aend_next  = 8'd0;
                skip_next  = 8'd0;
                eend_next  = 8'd0;
                acc_next   = '0;
                hf_next    = '0;
                flags_next = 8'd0;
                seen_next  = 1'b0;
                poff_next  = 8'd0;
                if (d != tsph_pkg::SYNC_BYTE)
                begin
                    err_next   = tsph_pkg::ERR_SYNC;
                    phase_next = PH_DRAIN;
                end
                else
                begin
                    err_next   = tsph_pkg::ERR_OK;
                    phase_next = PH_HDR;
                end
            end
            else if (phase_reg != PH_WAIT)
            begin
                active   = 1'b1;
                pos_next = pos_inc;
                unique case (phase_reg)
                    PH_HDR:
                    begin
                        hf_next = {hf_reg[15:0], d};
                        if (pos_inc >= 8'd4)
                        begin
                            if (hf_next[5])
                            begin
                                phase_next = PH_AFLEN;
                            end
                            else
                            begin
                                do_finish = 1'b1;
                            end
                        end
                    end
                    PH_AFLEN:
                    begin
                        aend_next = len_end;
                        if (d == 8'd0)
                        begin
                            do_stuff = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_AFFLAGS;
                        end
                    end
                    PH_AFFLAGS:
                    begin
                        flags_next = d;
                        if ((aend_reg == pos_inc) || ({1'b0, aend_reg} + 9'd1 == {1'b0, pos_inc}))
                        begin
                            do_stuff = 1'b1;
                        end
                        else
                        begin
                            do_next  = 1'b1;
                            nf_stage = PH_PCR;
                        end
                    end
                    PH_PCR:
                    begin
                        acc_next  = {acc_reg[ACC_BITS-9:0], d};
                        skip_next = skip_dec;
                        if (skip_dec == 8'd0)
                        begin
                            seen_next = 1'b1;
                            do_next   = 1'b1;
                            nf_stage  = PH_OPCR;
                        end
                    end
                    PH_OPCR:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 8'd0)
                        begin
                            do_next  = 1'b1;
                            nf_stage = PH_SPLICE;
                        end
                    end
                    PH_SPLICE:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 8'd0)
                        begin
                            do_next  = 1'b1;
                            nf_stage = PH_PRIVLEN;
                        end
                    end
                    PH_PRIVLEN:
                    begin
                        skip_next = d;
                        if (d == 8'd0)
                        begin
                            do_next  = 1'b1;
                            nf_stage = PH_EXTLEN;
                        end
                        else
                        begin
                            phase_next = PH_SKIPPRIV;
                        end
                    end
                    PH_SKIPPRIV:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 8'd0)
                        begin
                            do_next  = 1'b1;
                            nf_stage = PH_EXTLEN;
                        end
                    end
                    PH_EXTLEN:
                    begin
                        eend_next  = len_end;
                        phase_next = PH_EXTFLAGS;
                    end
                    PH_EXTFLAGS:
                    begin
                        skip_next = ext_skip;
                        if (ext_skip == 8'd0)
                        begin
                            do_stuff = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SKIPEXT;
                        end
                    end
                    PH_SKIPEXT:
                    begin
                        skip_next = skip_dec;
                        if (skip_dec == 8'd0)
                        begin
                            do_stuff = 1'b1;
                        end
                    end
                    PH_STUFF:
                    begin
                        if (d != tsph_pkg::STUFF_BYTE)
                        begin
                            err_next   = tsph_pkg::ERR_STUFF;
                            phase_next = PH_DRAIN;
                        end
                        else if (pos_inc >= aend_reg)
                        begin
                            do_finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        // payload and drain bytes only advance the position
                    end
                endcase
            end
        end

        // pick the next optional field that the flag byte announces
        if (do_next)
        begin
            if ((nf_stage <= PH_PCR) && flags_next[4])
            begin
                phase_next = PH_PCR;
                skip_next  = 8'd6;
                acc_next   = '0;
            end
            else if ((nf_stage <= PH_OPCR) && flags_next[3])
            begin
                phase_next = PH_OPCR;
                skip_next  = 8'd6;
            end
            else if ((nf_stage <= PH_SPLICE) && flags_next[2])
            begin
                phase_next = PH_SPLICE;
                skip_next  = 8'd1;
            end
            else if ((nf_stage <= PH_PRIVLEN) && flags_next[1])
            begin
                phase_next = PH_PRIVLEN;
            end
            else if ((nf_stage <= PH_EXTLEN) && flags_next[0])
            begin
                phase_next = PH_EXTLEN;
            end
            else
            begin
                do_stuff = 1'b1;
            end
        end

        if (do_stuff)
        begin
            if (pos_next >= aend_next)
            begin
                do_finish = 1'b1;
            end
            else
            begin
                phase_next = PH_STUFF;
            end
        end

        if (do_finish)
        begin
            poff_next  = hf_next[4] ? pos_next : tsph_pkg::PACKET_SIZE;
            phase_next = PH_PAYLOAD;
        end

        would_emit = active && (pos_next >= tsph_pkg::PACKET_SIZE);
        final_err  = ((err_next == tsph_pkg::ERR_OK) && (phase_next != PH_PAYLOAD)) ?
                     tsph_pkg::ERR_OVERRUN : err_next;

        if (would_emit)
        begin
            phase_next = PH_WAIT;
        end
    end

    // 27 MHz reference: base * 300 + extension, 300 = 256 + 32 + 8 + 4
    assign pcr_base  = acc_next[ACC_BITS-1:ACC_BITS-PCR_BASE_BITS_W];
    assign pcr_ext   = acc_next[tsph_pkg::PCR_EXT_BITS-1:0];
    assign base_wide = {{(tsph_pkg::PCR_BITS-PCR_BASE_BITS_W){1'b0}}, pcr_base};
    assign pcr_full  = (base_wide << 8) + (base_wide << 5) + (base_wide << 3)
                     + (base_wide << 2)
                     + {{(tsph_pkg::PCR_BITS-tsph_pkg::PCR_EXT_BITS){1'b0}}, pcr_ext};

    always_comb
    begin
        result            = '0;
        result.error_code = final_err;
        if (final_err == tsph_pkg::ERR_OK)
        begin
            result.pid                = hf_next[20:8];
            result.payload_start      = hf_next[22];
            result.transport_error    = hf_next[23];
            result.priority_bit       = hf_next[21];
            result.scrambling         = hf_next[7:6];
            result.adaptation_control = hf_next[5:4];
            result.continuity         = hf_next[3:0];
            result.af_flags           = flags_next;
            result.pcr_valid          = seen_next;
            result.pcr_value          = seen_next ? pcr_full : '0;
            result.payload_offset     = poff_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 8'd0;
            phase_reg <= PH_WAIT;
            aend_reg  <= 8'd0;
            skip_reg  <= 8'd0;
            eend_reg  <= 8'd0;
            acc_reg   <= '0;
            hf_reg    <= '0;
            flags_reg <= 8'd0;
            seen_reg  <= 1'b0;
            err_reg   <= tsph_pkg::ERR_OK;
            poff_reg  <= 8'd0;
        end
        else if (advance)
        begin
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
            aend_reg  <= aend_next;
            skip_reg  <= skip_next;
            eend_reg  <= eend_next;
            acc_reg   <= acc_next;
            hf_reg    <= hf_next;
            flags_reg <= flags_next;
            seen_reg  <= seen_next;
            err_reg   <= err_next;
            poff_reg  <= poff_next;
        end
    end

endmodule

[sv/tsph_out_stage.sv]
// ----------------------------------------------------------------------------
// tsph_out_stage
// Result register: holds one packet summary until the consumer takes it.
// ----------------------------------------------------------------------------
module tsph_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  tsph_pkg::result_t result_in,
    output logic              out_valid,
    input  logic              out_stall,
    output tsph_pkg::result_t result
);

    logic              valid_reg;
    logic              valid_next;
    tsph_pkg::result_t result_reg;

    // hold while stalled, drop once taken
    assign valid_next = load || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid = valid_reg;
    assign result    = result_reg;

endmodule

[sv/ts_packet_header_parser.sv]
// ----------------------------------------------------------------------------
// ts_packet_header_parser
// Transport stream packet header parser: one byte per transfer in, one
// summary per packet out on the last byte of the packet.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+----------------------------------
//  in      | input     | in_valid / in_stall | data_byte, first_of_packet
//  out     | output    | out_valid/out_stall | error_code .. payload_offset
//
//  One byte per cycle sustained unless in_stall holds the input; a summary
//  follows the last byte through input register, parse and result register.
//  The parse state updates in a single pass, so the loop through the state
//  registers sets the one-byte-per-cycle figure.
//  Reset clears all control state; no clearing pass is needed.
//  in_stall rises only when a byte that closes a packet meets a full result
//  register whose transfer is stalled; all other bytes keep flowing.
// ----------------------------------------------------------------------------
module ts_packet_header_parser
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [7:0]                           data_byte,
    input  logic                                 first_of_packet,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [1:0]                           error_code,
    output logic [tsph_pkg::PID_BITS-1:0]        pid,
    output logic                                 payload_start,
    output logic                                 transport_error,
    output logic                                 priority_bit,
    output logic [1:0]                           scrambling,
    output logic [1:0]                           adaptation_control,
    output logic [3:0]                           continuity,
    output logic [7:0]                           af_flags,
    output logic                                 pcr_valid,
    output logic [tsph_pkg::PCR_BITS-1:0]        pcr_value,
    output logic [7:0]                           payload_offset
);

    logic               item_valid;
    tsph_pkg::in_item_t item;
    logic               hold;
    logic               advance;
    logic               would_emit;
    tsph_pkg::result_t  parse_result;
    tsph_pkg::result_t  out_result;

    // block the parser only when its result has nowhere to go
    assign hold    = would_emit && out_valid && out_stall;
    assign advance = item_valid && !hold;

    tsph_in_stage u_in_stage
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .data_byte       (data_byte),
        .first_of_packet (first_of_packet),
        .hold            (hold),
        .item_valid      (item_valid),
        .item            (item)
    );

    tsph_parse u_parse
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .would_emit (would_emit),
        .result     (parse_result)
    );

    tsph_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && would_emit),
        .result_in (parse_result),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (out_result)
    );

    assign error_code         = out_result.error_code;
    assign pid                = out_result.pid;
    assign payload_start      = out_result.payload_start;
    assign transport_error    = out_result.transport_error;
    assign priority_bit       = out_result.priority_bit;
    assign scrambling         = out_result.scrambling;
    assign adaptation_control = out_result.adaptation_control;
    assign continuity         = out_result.continuity;
    assign af_flags           = out_result.af_flags;
    assign pcr_valid          = out_result.pcr_valid;
    assign pcr_value          = out_result.pcr_value;
    assign payload_offset     = out_result.payload_offset;

endmodule

[sv/tsph_checker.sv]
// ----------------------------------------------------------------------------
// tsph_checker
// Port-level checks of the packet header parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ts_packet_header_parser_defines.svh"

module tsph_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic [7:0]                    data_byte,
    input logic                          first_of_packet,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    error_code,
    input logic [tsph_pkg::PID_BITS-1:0] pid,
    input logic                          payload_start,
    input logic                          transport_error,
    input logic                          priority_bit,
    input logic [1:0]                    scrambling,
    input logic [1:0]                    adaptation_control,
    input logic [3:0]                    continuity,
    input logic [7:0]                    af_flags,
    input logic                          pcr_valid,
    input logic [tsph_pkg::PCR_BITS-1:0] pcr_value,
    input logic [7:0]                    payload_offset
);

    logic err_result;
    logic fields_clear;
    logic out_stalled;
    logic in_seen;

    assign err_result   = out_valid && (error_code != tsph_pkg::ERR_OK);
    assign fields_clear = (pid == '0) && !payload_start && !transport_error && !priority_bit
                       && (scrambling == 2'd0) && (adaptation_control == 2'd0)
                       && (continuity == 4'd0) && (af_flags == 8'd0) && !pcr_valid
                       && (pcr_value == '0) && (payload_offset == 8'd0);
    assign out_stalled  = out_valid && out_stall;
    assign in_seen      = in_valid || in_stall || (data_byte != 8'd0) || first_of_packet;

    `TSPH_ASSERT_SAME(a_err_clears_fields, clk, rst_n, err_result, fields_clear, "error result with nonzero fields")
    `TSPH_ASSERT_SAME(a_pcr_zero_when_absent, clk, rst_n, out_valid && !pcr_valid, pcr_value == '0, "pcr_value set without pcr_valid")
    `TSPH_ASSERT_SAME(a_no_payload_offset, clk, rst_n, out_valid && (error_code == tsph_pkg::ERR_OK) && !adaptation_control[0] && in_seen | !in_seen, !(out_valid && (error_code == tsph_pkg::ERR_OK) && !adaptation_control[0]) || (payload_offset == tsph_pkg::PACKET_SIZE), "payload offset not packet size without payload")
    `TSPH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, out_valid && $stable(error_code) && $stable(pid) && $stable(pcr_value) && $stable(payload_offset), "stalled result changed")

endmodule

bind ts_packet_header_parser tsph_checker u_tsph_checker (.*);
